FILE: rtl/cdh_pkg.sv
// cdh_pkg: shared types and constants of the clench detector
// no dependencies; used by every module of the block by scoped names
`default_nettype none

package cdh_pkg;

    // field widths
    localparam int unsigned C_VAL_BITS   = 16;
    localparam int unsigned C_STAMP_BITS = 32;

    // configuration register indexes
    localparam int unsigned C_IDX_BITS = 2;
    typedef enum logic [C_IDX_BITS-1:0] {
        REG_ZERO_LEVEL       = 2'd0,
        REG_MAX_PRESSURE     = 2'd1,
        REG_CLENCH_THRESHOLD = 2'd2,
        REG_HOLD_MS          = 2'd3
    } t_reg_idx;

    // register reset values
    localparam logic [C_VAL_BITS-1:0] C_RST_ZERO_LEVEL   = 16'd0;
    localparam logic [C_VAL_BITS-1:0] C_RST_MAX_PRESSURE = 16'd1023;
    localparam logic [C_VAL_BITS-1:0] C_RST_THRESHOLD    = 16'd200;
    localparam logic [C_VAL_BITS-1:0] C_RST_HOLD_MS      = 16'd500;

    // release level is threshold divided by four
    localparam int unsigned C_DISARM_SHIFT = 2;

    // configuration bundle
    typedef struct packed {
        logic [C_VAL_BITS-1:0] zero_level;
        logic [C_VAL_BITS-1:0] max_pressure;
        logic [C_VAL_BITS-1:0] clench_threshold;
        logic [C_VAL_BITS-1:0] hold_ms;
    } t_cfg;

    // per-result flags
    typedef struct packed {
        logic clenching;
        logic release_event;
        logic clench_event;
    } t_flags;

endpackage

`default_nettype wire

FILE: rtl/cdh_cfg_regs.sv
// cdh_cfg_regs: configuration register bank of the clench detector
// depends on cdh_pkg for the register indexes and the t_cfg bundle
`default_nettype none

module cdh_cfg_regs (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_wr_en,
    input  wire logic [cdh_pkg::C_IDX_BITS-1:0]   i_wr_index,
    input  wire logic [cdh_pkg::C_VAL_BITS-1:0]   i_wr_data,
    output cdh_pkg::t_cfg                         o_cfg
);

    cdh_pkg::t_cfg r_cfg;

    // register writes, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.zero_level       <= cdh_pkg::C_RST_ZERO_LEVEL;
            r_cfg.max_pressure     <= cdh_pkg::C_RST_MAX_PRESSURE;
            r_cfg.clench_threshold <= cdh_pkg::C_RST_THRESHOLD;
            r_cfg.hold_ms          <= cdh_pkg::C_RST_HOLD_MS;
        end else if (i_wr_en) begin
            case (cdh_pkg::t_reg_idx'(i_wr_index))
                cdh_pkg::REG_ZERO_LEVEL:       r_cfg.zero_level       <= i_wr_data;
                cdh_pkg::REG_MAX_PRESSURE:     r_cfg.max_pressure     <= i_wr_data;
                cdh_pkg::REG_CLENCH_THRESHOLD: r_cfg.clench_threshold <= i_wr_data;
                cdh_pkg::REG_HOLD_MS:          r_cfg.hold_ms          <= i_wr_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

FILE: rtl/cdh_core.sv
// cdh_core: pressure clamp, hysteresis arming and hold timer of the detector
// depends on cdh_pkg; state advances only when i_step is high
`default_nettype none

module cdh_core #(
    parameter int unsigned TIME_BITS = 32
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_step,
    input  wire cdh_pkg::t_cfg                      i_cfg,
    input  wire logic [cdh_pkg::C_VAL_BITS-1:0]     i_charge,
    input  wire logic [cdh_pkg::C_STAMP_BITS-1:0]   i_now,
    output logic      [cdh_pkg::C_VAL_BITS-1:0]     o_pressure,
    output cdh_pkg::t_flags                         o_flags
);

    logic                               r_armed;
    logic                               r_pending;
    logic                               r_active;
    logic [cdh_pkg::C_VAL_BITS-1:0]     r_prev;
    logic [TIME_BITS-1:0]               r_arm_time;

    logic                               n_armed;
    logic                               n_pending;
    logic                               n_active;
    logic [TIME_BITS-1:0]               n_arm_time;

    logic [TIME_BITS+cdh_pkg::C_STAMP_BITS-1:0] w_now_ext;
    logic [TIME_BITS+cdh_pkg::C_VAL_BITS-1:0]   w_hold_ext;
    logic [TIME_BITS-1:0]               w_now;
    logic [TIME_BITS-1:0]               w_hold;
    logic [TIME_BITS-1:0]               w_elapsed;
    logic [cdh_pkg::C_VAL_BITS-1:0]     w_diff;
    logic [cdh_pkg::C_VAL_BITS-1:0]     w_p;
    logic [cdh_pkg::C_VAL_BITS-1:0]     w_release_lvl;
    logic                               w_arm;
    logic                               w_pend_mid;
    logic                               w_fire;
    logic                               w_rel;

    // timestamp and hold kept to TIME_BITS
    assign w_now_ext  = {{TIME_BITS{1'b0}}, i_now};
    assign w_now      = w_now_ext[TIME_BITS-1:0];
    assign w_hold_ext = {{TIME_BITS{1'b0}}, i_cfg.hold_ms};
    assign w_hold     = w_hold_ext[TIME_BITS-1:0];

    // baseline subtract and clamp
    assign w_diff = i_charge - i_cfg.zero_level;
    always_comb begin
        if (i_charge < i_cfg.zero_level) begin
            w_p = '0;
        end else if (w_diff > i_cfg.max_pressure) begin
            w_p = i_cfg.max_pressure;
        end else begin
            w_p = w_diff;
        end
    end

    // hysteresis arm and disarm
    assign w_release_lvl = i_cfg.clench_threshold >> cdh_pkg::C_DISARM_SHIFT;
    assign w_arm = !r_armed && (w_p > r_prev) && (w_p > i_cfg.clench_threshold);

    always_comb begin
        if (r_armed) begin
            n_armed = !((w_p < r_prev) && (w_p <= w_release_lvl));
        end else begin
            n_armed = w_arm;
        end
    end

    assign w_pend_mid = r_pending || w_arm;
    assign n_arm_time = w_arm ? w_now : r_arm_time;
    assign w_elapsed  = w_now - n_arm_time;

    // hold timer event, clench wins over release
    assign w_fire = w_pend_mid && n_armed && (w_elapsed > w_hold);
    assign w_rel  = !w_fire && r_active && !n_armed;

    always_comb begin
        n_pending = w_pend_mid;
        n_active  = r_active;
        if (w_fire) begin
            n_pending = 1'b0;
            n_active  = 1'b1;
        end else if (w_rel) begin
            n_pending = 1'b0;
            n_active  = 1'b0;
        end
    end

    // state update per transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed    <= 1'b0;
            r_pending  <= 1'b0;
            r_active   <= 1'b0;
            r_prev     <= '0;
            r_arm_time <= '0;
        end else if (i_step) begin
            r_armed    <= n_armed;
            r_pending  <= n_pending;
            r_active   <= n_active;
            r_prev     <= w_p;
            r_arm_time <= n_arm_time;
        end
    end

    assign o_pressure            = w_p;
    assign o_flags.clench_event  = w_fire;
    assign o_flags.release_event = w_rel;
    assign o_flags.clenching     = n_active;

endmodule

`default_nettype wire

FILE: rtl/clench_detector_hysteresis_hold.sv
// clench_detector_hysteresis_hold: top level, input and result registers
// depends on cdh_pkg, cdh_cfg_regs and cdh_core
//
//   channel   direction  handshake                    payload
//   s_axis    in         i_s_axis_tvalid/o_s_axis_tready  tdata = charge_time, now_ms
//   m_axis    out        o_m_axis_tvalid/i_m_axis_tready  tdata = pressure_value, tuser = flags
//   cfg       in         i_cfg_valid/o_cfg_ready      i_cfg_index, i_cfg_data
//
// one sample per cycle sustained while the receiver takes each result; a sample passes
// the input register, then the detector logic into the result register
// synchronous active-low reset clears the pipeline valids, detector state and config registers
// a stalled result holds its register; an empty input register still takes one more sample
// configuration writes complete in the cycle they are presented
`default_nettype none

module clench_detector_hysteresis_hold #(
    parameter int unsigned TIME_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input stream
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [47:0] i_s_axis_tdata,   // [15:0] charge_time, [47:16] now_ms
    // result stream
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic      [15:0] o_m_axis_tdata,   // [15:0] pressure_value
    output logic      [7:0]  o_m_axis_tuser,   // [0] clench_event, [1] release_event,
                                               // [2] clenching, [7:3] zero
    // configuration writes
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    cdh_pkg::t_cfg                     w_cfg;
    cdh_pkg::t_flags                   w_flags;
    logic [cdh_pkg::C_VAL_BITS-1:0]    w_pressure;
    logic                              w_advance;

    logic                              r_in_valid;
    logic [cdh_pkg::C_VAL_BITS-1:0]    r_charge;
    logic [cdh_pkg::C_STAMP_BITS-1:0]  r_now;
    logic                              r_out_valid;
    logic [cdh_pkg::C_VAL_BITS-1:0]    r_pressure;
    cdh_pkg::t_flags                   r_flags;

    // configuration bank
    assign o_cfg_ready = 1'b1;

    cdh_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    // pipeline flow control
    assign w_advance       = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_charge <= i_s_axis_tdata[15:0];
            r_now    <= i_s_axis_tdata[47:16];
        end
    end

    // detector logic
    cdh_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (w_advance),
        .i_cfg      (w_cfg),
        .i_charge   (r_charge),
        .i_now      (r_now),
        .o_pressure (w_pressure),
        .o_flags    (w_flags)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_pressure <= w_pressure;
            r_flags    <= w_flags;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_pressure;
    assign o_m_axis_tuser  = {5'd0, r_flags.clenching, r_flags.release_event,
                              r_flags.clench_event};

    // at most one event per result
    a_one_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_flags.clench_event && r_flags.release_event))
        else $error("clench and release event in the same result");

    // a clench event leaves the clench active
    a_clench_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_flags.clench_event) |-> r_flags.clenching)
        else $error("clench event without active clench");

    // a release event ends the clench
    a_release_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_flags.release_event) |-> !r_flags.clenching)
        else $error("release event with clench still active");

    // no result appears without a held sample behind it
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !$past(r_out_valid)) |-> $past(r_in_valid))
        else $error("result produced without an input sample");

endmodule

`default_nettype wire

FILE: dv/testbench.sv
// testbench: self-checking bench for clench_detector_hysteresis_hold
// depends on cdh_pkg and the rtl top; predicts every result in-line and checks it on the stream
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned C_LATENCY     = 2;
    localparam int unsigned C_CYCLE_LIMIT = 200000;
    localparam int unsigned C_PHASES      = 12;
    localparam int unsigned C_PHASE_ITEMS = 100;

    // one sample as it travels on tdata: [15:0] charge_time, [47:16] now_ms
    typedef struct packed {
        logic [31:0] stamp;
        logic [15:0] charge;
    } t_sample;

    // one expected detector result
    typedef struct packed {
        logic [15:0]     pressure;
        cdh_pkg::t_flags flags;
    } t_result;

    // one register write
    typedef struct packed {
        cdh_pkg::t_reg_idx idx;
        logic [15:0]       val;
    } t_reg_write;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;

    logic        s_valid = 1'b0;
    t_sample     s_item  = '0;
    logic        s_ready;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_data;
    logic [7:0]  m_user;
    logic        cfg_valid = 1'b0;
    cdh_pkg::t_reg_idx cfg_index = cdh_pkg::REG_ZERO_LEVEL;
    logic [15:0] cfg_data  = '0;
    logic        cfg_ready;

    // stimulus and expectation stores
    t_sample    sample_q[$];
    t_result    pressure_q[$];
    t_reg_write cfg_q[$];

    // idle rates and the long receiver hold-off
    int unsigned send_idle_pct  = 0;
    int unsigned recv_idle_pct  = 0;
    int unsigned recv_hold_left = 0;

    // settings the stimulus is shaped for
    int unsigned cur_zero = cdh_pkg::C_RST_ZERO_LEVEL;
    int unsigned cur_thr  = cdh_pkg::C_RST_THRESHOLD;
    int unsigned cur_hold = cdh_pkg::C_RST_HOLD_MS;
    logic [31:0] gen_ms   = '0;

    // detector copy: registers and state
    logic [15:0] det_zero   = cdh_pkg::C_RST_ZERO_LEVEL;
    logic [15:0] det_max    = cdh_pkg::C_RST_MAX_PRESSURE;
    logic [15:0] det_thr    = cdh_pkg::C_RST_THRESHOLD;
    logic [15:0] det_hold   = cdh_pkg::C_RST_HOLD_MS;
    logic        det_armed  = 1'b0;
    logic        det_first  = 1'b0;
    logic        det_active = 1'b0;
    logic [15:0] det_prev   = '0;
    logic [31:0] det_arm_ms = '0;

    int unsigned errors     = 0;
    int unsigned n_sent     = 0;
    int unsigned n_settings = 0;
    int unsigned n_clench   = 0;
    int unsigned n_release  = 0;
    int unsigned cycle_cnt  = 0;

    clench_detector_hysteresis_hold u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_item),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // detector prediction for one accepted sample, advances the copied state
    function automatic t_result detect_step(logic [15:0] charge, logic [31:0] stamp);
        logic [15:0] p;
        logic [15:0] diff;
        logic [31:0] elapsed;
        t_result     r;
        if (charge < det_zero) begin
            p = '0;
        end else begin
            diff = charge - det_zero;
            p    = (diff > det_max) ? det_max : diff;
        end
        // hysteresis: arm on a rising sample above threshold, disarm falling to a quarter
        if (det_armed) begin
            if (p < det_prev && p <= (det_thr >> cdh_pkg::C_DISARM_SHIFT))
                det_armed = 1'b0;
        end else if (p > det_prev && p > det_thr) begin
            det_armed  = 1'b1;
            det_first  = 1'b1;
            det_arm_ms = stamp;
        end
        elapsed = stamp - det_arm_ms;
        r.flags = '0;
        // clench event has priority over release
        if (det_first && det_armed && elapsed > {16'd0, det_hold}) begin
            det_first          = 1'b0;
            det_active         = 1'b1;
            r.flags.clench_event = 1'b1;
        end else if (det_active && !det_armed) begin
            det_first           = 1'b0;
            det_active          = 1'b0;
            r.flags.release_event = 1'b1;
        end
        det_prev          = p;
        r.pressure        = p;
        r.flags.clenching = det_active;
        return r;
    endfunction

    // sample driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                pressure_q.push_back(detect_step(s_item.charge, s_item.stamp));
            if (!s_valid || s_ready) begin
                if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_item  <= sample_q.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // register write driver
    always @(posedge i_clk) begin
        t_reg_write w;
        if (!i_rst_n) begin
            cfg_valid <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    cdh_pkg::REG_ZERO_LEVEL:       det_zero = cfg_data;
                    cdh_pkg::REG_MAX_PRESSURE:     det_max  = cfg_data;
                    cdh_pkg::REG_CLENCH_THRESHOLD: det_thr  = cfg_data;
                    cdh_pkg::REG_HOLD_MS:          det_hold = cfg_data;
                    default: ;
                endcase
            end
            if (!cfg_valid || cfg_ready) begin
                if (cfg_q.size() != 0) begin
                    w = cfg_q.pop_front();
                    cfg_valid <= 1'b1;
                    cfg_index <= w.idx;
                    cfg_data  <= w.val;
                end else begin
                    cfg_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver back-pressure
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                n_clench  = n_clench + m_user[0];
                n_release = n_release + m_user[1];
                if (pressure_q.size() == 0) begin
                    $display("%0t: result with nothing expected, pressure %0d tuser %b",
                             $time, m_data, m_user);
                    errors++;
                end else begin
                    want = pressure_q.pop_front();
                    if (m_data !== want.pressure) begin
                        $display("%0t: pressure_value expected %0d actual %0d",
                                 $time, want.pressure, m_data);
                        errors++;
                    end
                    if (m_user[0] !== want.flags.clench_event) begin
                        $display("%0t: clench_event expected %b actual %b",
                                 $time, want.flags.clench_event, m_user[0]);
                        errors++;
                    end
                    if (m_user[1] !== want.flags.release_event) begin
                        $display("%0t: release_event expected %b actual %b",
                                 $time, want.flags.release_event, m_user[1]);
                        errors++;
                    end
                    if (m_user[2] !== want.flags.clenching) begin
                        $display("%0t: clenching expected %b actual %b",
                                 $time, want.flags.clenching, m_user[2]);
                        errors++;
                    end
                    if (m_user[7:3] !== 5'd0) begin
                        $display("%0t: tuser spare bits expected %b actual %b",
                                 $time, 5'd0, m_user[7:3]);
                        errors++;
                    end
                end
            end
            if (recv_hold_left > 0) begin
                m_ready        <= 1'b0;
                recv_hold_left <= recv_hold_left - 1;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // run limit
    initial begin
        while (cycle_cnt < C_CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_cnt, pressure_q.size());
        $display("testbench failed");
        $finish;
    end

    // queue one sample, charge saturates at the field top
    task automatic push_sample(int unsigned charge, logic [31:0] stamp);
        t_sample s;
        s.charge = (charge > 65535) ? 16'hFFFF : 16'(charge);
        s.stamp  = stamp;
        sample_q.push_back(s);
        n_sent++;
    endtask

    // wait until the sender is empty and every result is back
    task automatic wait_idle();
        do @(negedge i_clk);
        while (sample_q.size() != 0 || s_valid || pressure_q.size() != 0);
        repeat (C_LATENCY + 2) @(negedge i_clk);
    endtask

    // write all four registers while idle
    task automatic write_settings(int unsigned z, int unsigned mx, int unsigned th,
                                  int unsigned hd);
        t_reg_write w;
        w.idx = cdh_pkg::REG_ZERO_LEVEL;       w.val = 16'(z);  cfg_q.push_back(w);
        w.idx = cdh_pkg::REG_MAX_PRESSURE;     w.val = 16'(mx); cfg_q.push_back(w);
        w.idx = cdh_pkg::REG_CLENCH_THRESHOLD; w.val = 16'(th); cfg_q.push_back(w);
        w.idx = cdh_pkg::REG_HOLD_MS;          w.val = 16'(hd); cfg_q.push_back(w);
        cur_zero = z;
        cur_thr  = th;
        cur_hold = hd;
        do @(negedge i_clk);
        while (cfg_q.size() != 0 || cfg_valid);
        n_settings++;
    endtask

    // one press: rise above threshold, linger, then fall to the release level
    task automatic push_press();
        int unsigned thr4;
        int unsigned step_ms;
        int unsigned lvl;
        int unsigned n;
        int unsigned k;
        thr4    = cur_thr >> cdh_pkg::C_DISARM_SHIFT;
        step_ms = cur_hold / 6 + 1;
        n = $urandom_range(1, 3);
        for (k = 1; k <= n; k++) begin
            lvl = (k == n) ? cur_thr + 1 + $urandom_range(0, 64) : cur_thr * k / (n + 1);
            gen_ms += $urandom_range(0, 2 * step_ms);
            push_sample(cur_zero + lvl, gen_ms);
        end
        n = $urandom_range(1, 10);
        for (k = 0; k < n; k++) begin
            lvl = thr4 + 1 + $urandom_range(0, cur_thr - thr4 + 64);
            gen_ms += $urandom_range(0, 2 * step_ms);
            push_sample(cur_zero + lvl, gen_ms);
        end
        // a few presses are cut off without a release
        if ($urandom_range(9) != 0) begin
            n = $urandom_range(1, 3);
            for (k = 1; k <= n; k++) begin
                lvl = (k == n) ? $urandom_range(0, thr4)
                               : thr4 + 1 + (cur_thr - thr4) * (n - k) / n;
                gen_ms += $urandom_range(0, 2 * step_ms);
                push_sample(cur_zero + lvl, gen_ms);
            end
        end
    endtask

    // main sequence
    initial begin
        int unsigned ph;
        int unsigned start;
        int unsigned r;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed, reset settings: saturation, hold edge, hysteresis, wrap, arming step
        push_sample(0, 32'd0);
        push_sample(65535, 32'd1000);
        push_sample(1023, 32'd1000);
        push_sample(1023, 32'd1500);
        push_sample(1023, 32'd1501);
        push_sample(900, 32'd1600);
        push_sample(51, 32'd1700);
        push_sample(50, 32'd1800);
        push_sample(201, 32'd1900);
        push_sample(300, 32'h7FFF_0000);
        push_sample(50, 32'h7FFF_0001);
        push_sample(200, 32'h7FFF_0002);
        push_sample(1000, 32'hFFFF_FF00);
        push_sample(1000, 32'h0000_00F4);
        push_sample(1000, 32'h0000_00F5);
        push_sample(0, 32'h0000_0100);
        push_sample(1000, 32'hFFFF_FFFF);
        push_sample(65535, 32'hFFFF_FFFF);
        wait_idle();

        // directed: charge below baseline and a zero clamp
        write_settings(1000, 0, 0, 0);
        push_sample(999, 32'd5);
        push_sample(1000, 32'd6);
        push_sample(65535, 32'd7);
        push_sample(0, 32'hFFFF_FFFF);
        wait_idle();

        // long receiver stall while the sender keeps offering
        write_settings(100, 1023, 200, 20);
        start = n_sent;
        while (n_sent - start < 60)
            push_press();
        recv_hold_left = 300;
        wait_idle();

        // random phases over settings and idle patterns
        for (ph = 0; ph < C_PHASES; ph++) begin
            send_idle_pct = (ph < 4) ? 9 : (ph < 8) ? 55 : 0;
            recv_idle_pct = (ph < 4) ? 55 : (ph < 8) ? 9 : 0;
            case (ph % 6)
                0: write_settings(100, 1023, 200, 20);
                1: write_settings(0, 65535, 0, 0);
                2: write_settings(65535, 65535, 65535, 65535);
                3: write_settings(0, 65535, 65534, 65535);
                4: write_settings(1000, 500, 300, 0);
                default: write_settings($urandom_range(0, 2000),
                                        $urandom_range(1) ? 65535 : $urandom_range(0, 3000),
                                        $urandom_range(0, 1500), $urandom_range(0, 300));
            endcase
            // start some phases just short of the timestamp wrap
            if (ph % 3 == 1)
                gen_ms = 32'hFFFF_FFFF - $urandom_range(0, 5000);
            start = n_sent;
            while (n_sent - start < C_PHASE_ITEMS) begin
                r = $urandom_range(99);
                if (r < 75)
                    push_press();
                else if (r < 95)
                    repeat ($urandom_range(1, 4)) push_sample($urandom_range(0, 65535), $urandom);
                else
                    gen_ms = $urandom;
            end
            wait_idle();
        end

        $display("ran %0d samples under %0d register settings, with stalls on both sides",
                 n_sent, n_settings);
        $display("saw %0d clench and %0d release events, %0d mismatches",
                 n_clench, n_release, errors);
        if (errors == 0 && pressure_q.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

`default_nettype wire
